// ===== design/trilinear_prolongation_3d_top_defines.svh =====
// Assertion helpers for the trilinear prolongation block
`ifndef TRILINEAR_PROLONGATION_3D_TOP_DEFINES_SVH
`define TRILINEAR_PROLONGATION_3D_TOP_DEFINES_SVH

// same-cycle implication
`define TP3_ASSERT_NOW(lbl, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error(msg);

// next-cycle implication
`define TP3_ASSERT_NEXT(lbl, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error(msg);

`endif

// ===== design/tp3_pkg.sv =====
package tp3_pkg;

	localparam int ADDR_BITS = 21;

	typedef enum logic [2:0] {
		REG_COARSE_WIDTH  = 3'd0,
		REG_COARSE_HEIGHT = 3'd1,
		REG_COARSE_DEPTH  = 3'd2,
		REG_FINE_WIDTH    = 3'd3,
		REG_FINE_HEIGHT   = 3'd4
	} cfg_reg_t;

	typedef struct packed {
		logic [ADDR_BITS-1:0] row0;
		logic [ADDR_BITS-1:0] row1;
		logic [ADDR_BITS-1:0] fx0;
		logic [7:0]           fw;
		logic [7:0]           mask;
		logic                 vend;
	} emit_ctl_t;

endpackage

// ===== design/tp3_emit.sv =====
module tp3_emit import tp3_pkg::*; #(
	parameter int SAMPLE_BITS = 24
) (
	input  logic                          clk,
	input  logic                          arst_n,
	input  logic                          ld_valid,
	output logic                          ld_ready,
	input  emit_ctl_t                     ld_ctl,
	input  logic signed [SAMPLE_BITS-1:0] ld_v [8],
	output logic                          out_valid,
	input  logic                          out_stall,
	output logic [ADDR_BITS-1:0]          fine_address,
	output logic signed [SAMPLE_BITS-1:0] value,
	output logic                          last,
	output logic                          volume_end
);

	logic                          busy_q;
	logic [2:0]                    n_q;
	emit_ctl_t                     ctl_q;
	logic signed [SAMPLE_BITS:0]   px_q [4];
	logic signed [SAMPLE_BITS-1:0] v0_q [4];
	logic                          ov_q;

	logic                          adv, fire, is_last;
	logic [2:0]                    n_next;
	logic signed [SAMPLE_BITS:0]   t [4];
	logic signed [SAMPLE_BITS+2:0] acc, shf;
	logic [ADDR_BITS-1:0]          addr;

	assign adv = !ov_q || !out_stall;
	assign fire = busy_q && adv;

	always_comb begin
		is_last = 1'b1;
		n_next = n_q;
		for (int m = 7; m >= 1; m--) begin
			if (ctl_q.mask[m] && 3'(m) > n_q) begin
				is_last = 1'b0;
				n_next = 3'(m);
			end
		end
	end

	always_comb begin
		for (int q = 0; q < 4; q++) begin
			t[q] = n_q[0] ? px_q[q] : (SAMPLE_BITS+1)'(v0_q[q]);
		end
		acc = (SAMPLE_BITS+3)'(t[0]);
		if (n_q[1]) acc = acc + (SAMPLE_BITS+3)'(t[1]);
		if (n_q[2]) acc = acc + (SAMPLE_BITS+3)'(t[2]);
		if (n_q[1] && n_q[2]) acc = acc + (SAMPLE_BITS+3)'(t[3]);
		shf = acc >>> (2'(n_q[0]) + 2'(n_q[1]) + 2'(n_q[2]));
		addr = (n_q[2] ? ctl_q.row1 : ctl_q.row0) + ctl_q.fx0
			- (n_q[1] ? ADDR_BITS'(ctl_q.fw) : '0) - ADDR_BITS'(n_q[0]);
	end

	assign ld_ready = !busy_q || (fire && is_last);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			ov_q <= 1'b0;
			n_q <= '0;
		end else begin
			if (fire) begin
				ov_q <= 1'b1;
			end else if (!out_stall) begin
				ov_q <= 1'b0;
			end
			if (ld_valid && ld_ready) begin
				busy_q <= 1'b1;
				n_q <= '0;
			end else if (fire) begin
				if (is_last) begin
					busy_q <= 1'b0;
				end else begin
					n_q <= n_next;
				end
			end
		end
	end

	always_ff @(posedge clk) begin
		if (ld_valid && ld_ready) begin
			ctl_q <= ld_ctl;
			for (int q = 0; q < 4; q++) begin
				px_q[q] <= (SAMPLE_BITS+1)'(ld_v[2*q]) + (SAMPLE_BITS+1)'(ld_v[2*q+1]);
				v0_q[q] <= ld_v[2*q];
			end
		end
		if (fire) begin
			fine_address <= addr;
			value <= shf[SAMPLE_BITS-1:0];
			last <= is_last;
			volume_end <= is_last && ctl_q.vend;
		end
	end

	assign out_valid = ov_q;

endmodule

// ===== design/trilinear_prolongation_3d_top.sv =====
// channel  | valid / stall        | payload
// in       | in_valid / in_stall  | sample
// out      | out_valid / out_stall| fine_address, value, last, volume_end
// cfg      | cfg_we               | cfg_index, cfg_data
//
// A sample passes through the fetch sequencer (store write, three plane
// buffer reads on the single read port, handoff); the result stage gives one
// result per cycle unless stalled: eight for an interior voxel, fewer at edges.
// Reset clears counters and control; the plane buffer is not cleared.
// A stalled output holds the result stage, which in turn holds the fetch side.
`include "trilinear_prolongation_3d_top_defines.svh"
module trilinear_prolongation_3d_top import tp3_pkg::*; #(
	parameter int MAX_WIDTH   = 64,
	parameter int MAX_HEIGHT  = 64,
	parameter int MAX_DEPTH   = 64,
	parameter int SAMPLE_BITS = 24
) (
	input  logic                          clk,
	input  logic                          arst_n,
	input  logic                          in_valid,
	output logic                          in_stall,
	input  logic signed [SAMPLE_BITS-1:0] sample,
	output logic                          out_valid,
	input  logic                          out_stall,
	output logic [ADDR_BITS-1:0]          fine_address,
	output logic signed [SAMPLE_BITS-1:0] value,
	output logic                          last,
	output logic                          volume_end,
	input  logic                          cfg_we,
	input  logic [2:0]                    cfg_index,
	input  logic [7:0]                    cfg_data
);

	localparam int XW = $clog2(MAX_WIDTH);
	localparam int YW = $clog2(MAX_HEIGHT);
	localparam int ZW = $clog2(MAX_DEPTH);
	localparam int DW = 12;
	localparam int MEM_DEPTH = 2 << (XW + YW);

	typedef enum logic [5:0] {
		F_IDLE = 6'b000001,
		F_R0   = 6'b000010,
		F_R1   = 6'b000100,
		F_R2   = 6'b001000,
		F_CAP  = 6'b010000,
		F_HAND = 6'b100000
	} fetch_t;

	logic [6:0] cw_q, ch_q, cd_q;
	logic [7:0] fw_q, fh_q;
	logic [XW-1:0] col_q, i_q;
	logic [YW-1:0] row_q, j_q;
	logic [ZW-1:0] pln_q, k_q;
	logic sel_q, cur_q, vend_q;
	fetch_t fst_q;

	logic [SAMPLE_BITS-1:0] mem [MEM_DEPTH];
	logic [SAMPLE_BITS-1:0] rd_q;
	logic [XW+YW:0] raddr, waddr;

	logic signed [SAMPLE_BITS-1:0] s_q, d010_q, d001_q, d011_q;
	logic signed [SAMPLE_BITS-1:0] l000_q, l010_q, l001_q, l011_q;
	logic [ADDR_BITS-1:0] t0_q, row0_q, row1_q;

	logic [DW-1:0] w_eff, h_eff, d_eff;
	logic accept, col_end, row_end, pln_end;
	logic ld_ready;
	emit_ctl_t ctl;
	logic signed [SAMPLE_BITS-1:0] ld_v [8];

	function automatic logic [DW-1:0] clamp_dim(input logic [6:0] v, input int maxv);
		logic [DW-1:0] r;
		r = DW'(v);
		if (v == 7'd0) r = DW'(1);
		else if (r > DW'(maxv)) r = DW'(maxv);
		return r;
	endfunction

	assign w_eff = clamp_dim(cw_q, MAX_WIDTH);
	assign h_eff = clamp_dim(ch_q, MAX_HEIGHT);
	assign d_eff = clamp_dim(cd_q, MAX_DEPTH);
	assign col_end = DW'(col_q) + DW'(1) >= w_eff;
	assign row_end = DW'(row_q) + DW'(1) >= h_eff;
	assign pln_end = DW'(pln_q) + DW'(1) >= d_eff;

	assign in_stall = fst_q != F_IDLE;
	assign accept = in_valid && !in_stall;
	assign waddr = {sel_q, row_q, col_q};

	always_comb begin
		unique case (fst_q)
			F_R0:    raddr = {cur_q, j_q - YW'(1), i_q};
			F_R1:    raddr = {!cur_q, j_q, i_q};
			default: raddr = {!cur_q, j_q - YW'(1), i_q};
		endcase
	end

	always_ff @(posedge clk) begin
		if (accept) mem[waddr] <= sample;
		rd_q <= mem[raddr];
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cw_q <= 7'd64;
			ch_q <= 7'd64;
			cd_q <= 7'd64;
			fw_q <= 8'd127;
			fh_q <= 8'd127;
			col_q <= '0;
			row_q <= '0;
			pln_q <= '0;
			sel_q <= 1'b0;
			fst_q <= F_IDLE;
		end else begin
			if (cfg_we) begin
				unique case (cfg_index)
					REG_COARSE_WIDTH:  cw_q <= cfg_data[6:0];
					REG_COARSE_HEIGHT: ch_q <= cfg_data[6:0];
					REG_COARSE_DEPTH:  cd_q <= cfg_data[6:0];
					REG_FINE_WIDTH:    fw_q <= cfg_data;
					REG_FINE_HEIGHT:   fh_q <= cfg_data;
					default: ;
				endcase
			end
			if (accept) begin
				if (col_end) begin
					col_q <= '0;
					if (row_end) begin
						row_q <= '0;
						sel_q <= !sel_q;
						pln_q <= pln_end ? '0 : pln_q + ZW'(1);
					end else begin
						row_q <= row_q + YW'(1);
					end
				end else begin
					col_q <= col_q + XW'(1);
				end
			end
			unique case (fst_q)
				F_IDLE: if (accept) fst_q <= F_R0;
				F_R0:   fst_q <= F_R1;
				F_R1:   fst_q <= F_R2;
				F_R2:   fst_q <= F_CAP;
				F_CAP:  fst_q <= F_HAND;
				F_HAND: if (ld_ready) fst_q <= F_IDLE;
				default: fst_q <= F_IDLE;
			endcase
		end
	end

	always_ff @(posedge clk) begin
		if (accept) begin
			s_q <= sample;
			i_q <= col_q;
			j_q <= row_q;
			k_q <= pln_q;
			cur_q <= sel_q;
			vend_q <= col_end && row_end && pln_end;
		end
		if (fst_q == F_R0) t0_q <= ADDR_BITS'(fh_q) * ADDR_BITS'({k_q, 1'b0});
		if (fst_q == F_R1) begin
			d010_q <= rd_q;
			row0_q <= ADDR_BITS'(fw_q * (ADDR_BITS'({j_q, 1'b0}) + t0_q));
		end
		if (fst_q == F_R2) begin
			d001_q <= rd_q;
			row1_q <= ADDR_BITS'(fw_q * (ADDR_BITS'({j_q, 1'b0}) + t0_q - ADDR_BITS'(fh_q)));
		end
		if (fst_q == F_CAP) d011_q <= rd_q;
		if (fst_q == F_HAND && ld_ready) begin
			l000_q <= s_q;
			l010_q <= d010_q;
			l001_q <= d001_q;
			l011_q <= d011_q;
		end
	end

	always_comb begin
		for (int n = 0; n < 8; n++) begin
			ctl.mask[n] = (!n[0] || i_q != '0) && (!n[1] || j_q != '0) && (!n[2] || k_q != '0);
		end
		ctl.row0 = row0_q;
		ctl.row1 = row1_q;
		ctl.fx0 = ADDR_BITS'({i_q, 1'b0});
		ctl.fw = fw_q;
		ctl.vend = vend_q;
		ld_v[0] = s_q;
		ld_v[1] = l000_q;
		ld_v[2] = d010_q;
		ld_v[3] = l010_q;
		ld_v[4] = d001_q;
		ld_v[5] = l001_q;
		ld_v[6] = d011_q;
		ld_v[7] = l011_q;
	end

	tp3_emit #(.SAMPLE_BITS(SAMPLE_BITS)) u_emit (
		.clk          (clk),
		.arst_n       (arst_n),
		.ld_valid     (fst_q == F_HAND),
		.ld_ready     (ld_ready),
		.ld_ctl       (ctl),
		.ld_v         (ld_v),
		.out_valid    (out_valid),
		.out_stall    (out_stall),
		.fine_address (fine_address),
		.value        (value),
		.last         (last),
		.volume_end   (volume_end)
	);

	`TP3_ASSERT_NEXT(a_accept_fetch, accept, fst_q == F_R0, "transfer did not start fetch")
	`TP3_ASSERT_NEXT(a_hand_idle, fst_q == F_HAND && ld_ready, fst_q == F_IDLE, "handoff stuck")
	`TP3_ASSERT_NOW(a_vend_last, out_valid && volume_end, last, "volume_end without last")

endmodule

// ===== dv/tb_trilinear_prolongation_3d_top.sv =====
`timescale 1ns / 100ps
module tb_trilinear_prolongation_3d_top;
	import tp3_pkg::*;

	localparam int MAXW = 64;
	localparam int MAXH = 64;
	localparam int MAXD = 64;
	localparam int WATCHDOG_LIMIT = 20000;
	localparam int N_RANDOM = 110;

	typedef struct {
		logic [20:0] addr;
		logic signed [23:0] val;
		logic lst;
		logic vend;
	} fine_pt_t;

	logic clk;
	logic arst_n;
	logic in_valid;
	logic in_stall;
	logic signed [23:0] sample;
	logic out_valid;
	logic out_stall;
	logic [20:0] fine_address;
	logic signed [23:0] value;
	logic last;
	logic volume_end;
	logic cfg_we;
	logic [2:0] cfg_index;
	logic [7:0] cfg_data;

	trilinear_prolongation_3d_top i_dut (
		.clk(clk), .arst_n(arst_n),
		.in_valid(in_valid), .in_stall(in_stall), .sample(sample),
		.out_valid(out_valid), .out_stall(out_stall),
		.fine_address(fine_address), .value(value), .last(last),
		.volume_end(volume_end),
		.cfg_we(cfg_we), .cfg_index(cfg_index), .cfg_data(cfg_data)
	);

	initial clk = 1'b0;
	always #2 clk = ~clk;

	// shadow of the block's registers, counters and plane buffers
	int unsigned cw, ch, cd, fw, fh;
	int unsigned col, row, pln, psel;
	logic signed [23:0] planes [2][MAXH][MAXW];

	fine_pt_t fine_q [$];
	int mismatches;
	int n_results;
	int n_samples;
	int n_volumes;
	int idle_cycles;
	int stall_left;
	bit stall_quiet;

	function automatic int unsigned clamp_dim(int unsigned v, int unsigned m);
		if (v == 0) return 1;
		return (v > m) ? m : v;
	endfunction

	task automatic predict_fine(input logic signed [23:0] s);
		int unsigned w, h, d, a, b, c, cur, prv;
		longint sum;
		longint unsigned ad;
		fine_pt_t p;
		int first;
		w = clamp_dim(cw, MAXW);
		h = clamp_dim(ch, MAXH);
		d = clamp_dim(cd, MAXD);
		cur = psel;
		prv = psel ^ 1;
		first = fine_q.size();
		planes[cur][row][col] = s;
		for (int n = 0; n < 8; n++) begin
			a = n & 1;
			b = (n >> 1) & 1;
			c = (n >> 2) & 1;
			if (a > col || b > row || c > pln) continue;
			sum = 0;
			for (int dc = 0; dc <= c; dc++)
				for (int db = 0; db <= b; db++)
					for (int da = 0; da <= a; da++)
						sum += planes[dc ? prv : cur][row - db][col - da];
			ad = longint'(2 * col - a) + longint'(fw) *
				(longint'(2 * row - b) + longint'(fh) * longint'(2 * pln - c));
			p.addr = ad[20:0];
			p.val = 24'(sum >>> (a + b + c));
			p.lst = 1'b0;
			p.vend = 1'b0;
			fine_q.push_back(p);
		end
		fine_q[fine_q.size() - 1].lst = 1'b1;
		if (col + 1 >= w && row + 1 >= h && pln + 1 >= d) begin
			fine_q[fine_q.size() - 1].vend = 1'b1;
			n_volumes++;
		end
		if (col + 1 >= w) begin
			col = 0;
			if (row + 1 >= h) begin
				row = 0;
				psel ^= 1;
				pln = (pln + 1 >= d) ? 0 : pln + 1;
			end else begin
				row++;
			end
		end else begin
			col++;
		end
	endtask

	function automatic int rand_gap();
		int r;
		r = $urandom_range(0, 99);
		if (r < 50) return 0;
		if (r < 90) return $urandom_range(1, 3);
		return $urandom_range(4, 20);
	endfunction

	// result checker
	always @(posedge clk) begin
		fine_pt_t e;
		if (arst_n && out_valid && !out_stall) begin
			n_results++;
			if (fine_q.size() == 0) begin
				mismatches++;
				if (mismatches <= 10)
					$display("unexpected transfer addr=%0d value=%0d", fine_address, value);
			end else begin
				e = fine_q.pop_front();
				if (fine_address !== e.addr || value !== e.val || last !== e.lst ||
				    volume_end !== e.vend) begin
					mismatches++;
					if (mismatches <= 10)
						$display("mismatch exp addr=%0d val=%0d last=%b vend=%b, got %0d %0d %b %b",
							e.addr, e.val, e.lst, e.vend, fine_address, value, last,
							volume_end);
				end
			end
		end
	end

	// output stall generator
	always @(posedge clk) begin
		int g;
		if (!arst_n || stall_quiet) begin
			out_stall <= 1'b0;
			stall_left <= 0;
		end else if (stall_left != 0) begin
			out_stall <= 1'b1;
			stall_left <= stall_left - 1;
		end else if ($urandom_range(0, 99) < 25) begin
			g = rand_gap();
			out_stall <= (g != 0);
			stall_left <= (g > 1) ? g - 1 : 0;
		end else begin
			out_stall <= 1'b0;
		end
	end

	// watchdog
	always @(posedge clk) begin
		if ((in_valid && !in_stall) || (out_valid && !out_stall) || !arst_n)
			idle_cycles <= 0;
		else
			idle_cycles <= idle_cycles + 1;
		if (idle_cycles >= WATCHDOG_LIMIT) begin
			$display("Mismatches found");
			$finish;
		end
	end

	// valid stays high after the transfer; drain() or a gap in the next call drops it
	task automatic send_sample(input logic signed [23:0] s);
		int g;
		g = rand_gap();
		if (g != 0) begin
			in_valid <= 1'b0;
			repeat (g) @(posedge clk);
		end
		in_valid <= 1'b1;
		sample <= s;
		@(posedge clk);
		while (in_stall) @(posedge clk);
		predict_fine(s);
		n_samples++;
	endtask

	task automatic drain();
		in_valid <= 1'b0;
		while (fine_q.size() != 0) @(posedge clk);
		repeat (12) @(posedge clk);
	endtask

	task automatic write_reg(input cfg_reg_t idx, input logic [7:0] d);
		cfg_we <= 1'b1;
		cfg_index <= idx;
		cfg_data <= d;
		@(posedge clk);
		case (idx)
			REG_COARSE_WIDTH: cw = d & 8'h7F;
			REG_COARSE_HEIGHT: ch = d & 8'h7F;
			REG_COARSE_DEPTH: cd = d & 8'h7F;
			REG_FINE_WIDTH: fw = d;
			REG_FINE_HEIGHT: fh = d;
			default: ;
		endcase
	endtask

	task automatic set_size(input logic [7:0] w, h, d, fwi, fhe);
		write_reg(REG_COARSE_WIDTH, w);
		write_reg(REG_COARSE_HEIGHT, h);
		write_reg(REG_COARSE_DEPTH, d);
		write_reg(REG_FINE_WIDTH, fwi);
		write_reg(REG_FINE_HEIGHT, fhe);
		cfg_we <= 1'b0;
	endtask

	function automatic logic signed [23:0] rand_sample();
		case ($urandom_range(0, 5))
			0: return 24'sh7FFFFF;
			1: return 24'sh800000;
			2: return 24'(signed'($urandom_range(0, 15)) - 8);
			default: return 24'($urandom());
		endcase
	endfunction

	typedef struct {
		logic signed [23:0] s;
		bit has_exp;
		logic [20:0] addr;
		logic signed [23:0] val;
	} dir_row_t;

	initial begin
		dir_row_t rows [$];
		dir_row_t r;
		int vol;
		arst_n = 1'b0;
		in_valid = 1'b0;
		sample = '0;
		cfg_we = 1'b0;
		cfg_index = REG_COARSE_WIDTH;
		cfg_data = '0;
		mismatches = 0;
		n_results = 0;
		n_samples = 0;
		n_volumes = 0;
		stall_quiet = 1'b0;
		cw = 64; ch = 64; cd = 64; fw = 127; fh = 127;
		col = 0; row = 0; pln = 0; psel = 0;
		repeat (4) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// after reset: first voxel of a 64^3 volume yields one point at addr 0
		r = '{24'sh7FFFFF, 1, 21'd0, 24'sh7FFFFF};
		rows.push_back(r);
		r = '{24'sh800000, 0, 0, 0};
		rows.push_back(r);
		foreach (rows[t]) begin
			if (rows[t].has_exp && fine_q.size() == 0) begin
				send_sample(rows[t].s);
				if (fine_q[0].addr !== rows[t].addr || fine_q[0].val !== rows[t].val) begin
					mismatches++;
					$display("directed row %0d prediction off", t);
				end
			end else begin
				send_sample(rows[t].s);
			end
		end
		drain();

		// 2x2x2 volume, extremes, in the tiny grid
		set_size(8'd2, 8'd2, 8'd2, 8'd3, 8'd3);
		for (int t = 0; t < 8; t++) send_sample((t & 1) ? 24'sh800000 : 24'sh7FFFFF);
		for (int t = 0; t < 8; t++) send_sample(24'sh800000 + t);
		drain();
		// zero sizes act as 1, oversize clamps, zero and large fine sizes
		set_size(8'd0, 8'hFF, 8'd0, 8'd0, 8'd0);
		for (int t = 0; t < 3; t++) send_sample(-24'sd1);
		drain();
		set_size(8'd0, 8'd0, 8'd0, 8'd255, 8'd255);
		send_sample(24'sd5);
		drain();
		set_size(8'd3, 8'd1, 8'd2, 8'd128, 8'd128);
		for (int t = 0; t < 6; t++) send_sample(rand_sample());
		drain();

		// random volumes with random sizes, mostly small
		while (n_samples < N_RANDOM - 8) begin
			if ($urandom_range(0, 9) == 0 && n_samples + 64 <= N_RANDOM)
				set_size(8'($urandom_range(33, 64)), 8'd1, 8'd1,
					8'($urandom()), 8'($urandom()));
			else
				set_size(8'($urandom_range(1, 5)), 8'($urandom_range(1, 3)),
					8'($urandom_range(1, 2)), 8'($urandom_range(1, 255)),
					8'($urandom_range(0, 255)));
			vol = n_volumes;
			stall_quiet = ($urandom_range(0, 3) == 0);
			while (n_volumes == vol) send_sample(rand_sample());
			drain();
		end
		stall_quiet = 1'b0;
		drain();
		$display("covered %0d samples, %0d fine points, %0d volumes", n_samples, n_results,
			n_volumes);
		$display("sizes from 1 to the maximum, clamped and zero registers, sample extremes");
		if (mismatches == 0)
			$display("No mismatches found");
		else
			$display("Mismatches found");
		$finish;
	end
endmodule
